/* src/text_console_char_engine_assert.svh */
// Assertion macros for the text console character engine.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset.
`define TCE_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("tce: invariant failed");

// Check that a consequent holds in the same cycle as its antecedent.
`define TCE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tce: same-cycle implication failed");

// Check that a consequent holds in the cycle after its antecedent.
`define TCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tce: next-cycle implication failed");

`else

`define TCE_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define TCE_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define TCE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* src/tce_pkg.sv */
// Shared constants for the text console character engine.
package tce_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field and word widths
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int MODE_W  = 2;
    localparam int CADDR_W = 11;
    localparam int OROW_W  = 5;
    localparam int OCOL_W  = 7;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COLOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    // Attribute after reset
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    // Tab stop spacing
    localparam int TAB_STOP = 8;

endpackage

/* src/tce_cell_ram.sv */
// Cell store: one write port and one registered read port.
module tce_cell_ram #(
    parameter int DEPTH  = tce_pkg::COLUMNS_DEF * tce_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [tce_pkg::CELL_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [tce_pkg::CELL_W-1:0] rd_data
);

    logic [tce_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tce_pkg::CELL_W-1:0] rd_data_reg;

    // Write one word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one word, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/text_console_char_engine.sv */
// Top level of the text console character engine: sequencer, cursor and cell store.

// A user sends one word per character, color change or cell read and gets back one
// word with the cursor position after it (and the cell for a read). All cell traffic
// goes through a single-write, single-read cell store. No new word is taken until the
// result word of the last one is registered. Newline and tab write space cells (up to
// COLUMNS) in the default color; form feed clears the whole store in the current color;
// a new line below the last row moves the store up one row.
// After reset the store is cleared to spaces in RESET_COLOR, during which s_ready
// stays low; default_color writes are taken at any time.
module text_console_char_engine #(
    parameter int COLUMNS = tce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tce_pkg::ROWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [tce_pkg::COLOR_W-1:0]   cfg_wr_data,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tce_pkg::MODE_W-1:0]    s_mode,
    input  logic [tce_pkg::CHAR_W-1:0]    s_char_code,
    input  logic [tce_pkg::COLOR_W-1:0]   s_color,
    input  logic [tce_pkg::CADDR_W-1:0]   s_cell_address,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tce_pkg::OROW_W-1:0]    m_cursor_row,
    output logic [tce_pkg::OCOL_W-1:0]    m_cursor_column,
    output logic [tce_pkg::CELL_W-1:0]    m_cell_data
);

    `include "text_console_char_engine_assert.svh"

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int MOVES  = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CX_W   = COL_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_FILL,
        S_SCROLL,
        S_DONE
    } state_t;

    state_t                        state_reg;
    logic [ROW_W-1:0]              row_reg;
    logic [COL_W-1:0]              col_reg;
    logic [tce_pkg::COLOR_W-1:0]   cur_color_reg;
    logic [tce_pkg::COLOR_W-1:0]   def_color_reg;
    logic [ADDR_W-1:0]             ptr_reg;
    logic [ADDR_W-1:0]             fill_last_reg;
    logic [tce_pkg::COLOR_W-1:0]   fill_color_reg;
    logic                          scroll_pend_reg;

    logic [tce_pkg::MODE_W-1:0]    item_mode_reg;
    logic [tce_pkg::CHAR_W-1:0]    item_char_reg;
    logic [tce_pkg::COLOR_W-1:0]   item_color_reg;
    logic [tce_pkg::CADDR_W-1:0]   item_addr_reg;
    logic [tce_pkg::CELL_W-1:0]    cell_data_reg;

    logic                          m_valid_reg;
    logic [tce_pkg::OROW_W-1:0]    m_row_reg;
    logic [tce_pkg::OCOL_W-1:0]    m_col_reg;
    logic [tce_pkg::CELL_W-1:0]    m_data_reg;

    // cell store ports
    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    logic [tce_pkg::CELL_W-1:0]    mem_wr_data;
    logic                          mem_rd_en;
    logic [ADDR_W-1:0]             mem_rd_addr;
    logic [tce_pkg::CELL_W-1:0]    mem_rd_data;

    // cursor arithmetic
    logic [ADDR_W-1:0]             row_base;
    logic [ADDR_W-1:0]             cur_addr;
    logic [ADDR_W-1:0]             line_last;
    logic [CX_W-1:0]               col_ext;
    logic [CX_W-1:0]               col_inc;
    logic [CX_W-1:0]               tab_next;
    logic                          tab_wrap;
    logic [CX_W-1:0]               tab_end;
    logic [ADDR_W-1:0]             tab_last;
    logic                          last_row;
    logic                          read_in_range;
    logic [31:0]                   item_addr_ext;
    logic                          scroll_reads;
    logic                          accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == S_IDLE);

    // Derive cursor addresses and tab stop
    assign row_base      = ADDR_W'(row_reg) * ADDR_W'(COLUMNS);
    assign cur_addr      = row_base + ADDR_W'(col_reg);
    assign line_last     = row_base + ADDR_W'(COLUMNS - 1);
    assign col_ext       = CX_W'(col_reg);
    assign col_inc       = col_ext + CX_W'(1);
    assign tab_next      = (col_ext + CX_W'(tce_pkg::TAB_STOP)) & ~CX_W'(tce_pkg::TAB_STOP - 1);
    assign tab_wrap      = (tab_next >= CX_W'(COLUMNS));
    assign tab_end       = tab_wrap ? CX_W'(COLUMNS) : tab_next;
    assign tab_last      = row_base + ADDR_W'(tab_end) - ADDR_W'(1);
    assign last_row      = (row_reg == ROW_W'(ROWS - 1));
    assign item_addr_ext = 32'(item_addr_reg);
    assign read_in_range = (item_addr_ext < 32'(CELLS));
    assign scroll_reads  = (ptr_reg < ADDR_W'(MOVES));

    // Steer the cell store ports
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = ptr_reg;
        mem_wr_data = {fill_color_reg, tce_pkg::CH_SPACE};
        mem_rd_en   = 1'b0;
        mem_rd_addr = ADDR_W'(item_addr_ext);
        case (state_reg)
            S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = {tce_pkg::RESET_COLOR, tce_pkg::CH_SPACE};
            end
            S_EXEC: begin
                if (item_mode_reg == tce_pkg::MODE_READ) begin
                    mem_rd_en = read_in_range;
                end else if (item_mode_reg == tce_pkg::MODE_PUT) begin
                    case (item_char_reg)
                        tce_pkg::CH_NEWLINE, tce_pkg::CH_TAB, tce_pkg::CH_BACKSPACE,
                        tce_pkg::CH_FORMFEED, tce_pkg::CH_RETURN: begin
                            mem_wr_en = 1'b0;
                        end
                        default: begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = cur_addr;
                            mem_wr_data = {cur_color_reg, item_char_reg};
                        end
                    endcase
                end
            end
            S_FILL: begin
                mem_wr_en = 1'b1;
            end
            S_SCROLL: begin
                mem_rd_en   = scroll_reads;
                mem_rd_addr = ptr_reg + ADDR_W'(COLUMNS);
                mem_wr_en   = (ptr_reg != '0);
                mem_wr_addr = ptr_reg - ADDR_W'(1);
                mem_wr_data = mem_rd_data;
            end
            default: begin
                mem_wr_en = 1'b0;
            end
        endcase
    end

    tce_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Sequence items, cursor, colors and the result word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            row_reg         <= '0;
            col_reg         <= '0;
            cur_color_reg   <= tce_pkg::RESET_COLOR;
            def_color_reg   <= tce_pkg::RESET_COLOR;
            ptr_reg         <= '0;
            scroll_pend_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                def_color_reg <= cfg_wr_data;
            end
            // drop the result word once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR: begin
                    if (ptr_reg == ADDR_W'(CELLS - 1)) begin
                        ptr_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        ptr_reg <= ptr_reg + ADDR_W'(1);
                    end
                end

                S_IDLE: begin
                    if (accept) begin
                        item_mode_reg  <= s_mode;
                        item_char_reg  <= s_char_code;
                        item_color_reg <= s_color;
                        item_addr_reg  <= s_cell_address;
                        state_reg      <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    cell_data_reg   <= '0;
                    scroll_pend_reg <= 1'b0;
                    ptr_reg         <= '0;
                    state_reg       <= S_DONE;
                    case (item_mode_reg)
                        tce_pkg::MODE_COLOR: begin
                            cur_color_reg <= item_color_reg;
                        end
                        tce_pkg::MODE_READ: begin
                            if (read_in_range) begin
                                state_reg <= S_READ;
                            end
                        end
                        tce_pkg::MODE_PUT: begin
                            case (item_char_reg)
                                tce_pkg::CH_NEWLINE: begin
                                    cur_color_reg   <= def_color_reg;
                                    fill_color_reg  <= def_color_reg;
                                    ptr_reg         <= cur_addr;
                                    fill_last_reg   <= line_last;
                                    col_reg         <= '0;
                                    scroll_pend_reg <= last_row;
                                    if (!last_row) begin
                                        row_reg <= row_reg + ROW_W'(1);
                                    end
                                    state_reg <= S_FILL;
                                end
                                tce_pkg::CH_TAB: begin
                                    cur_color_reg  <= def_color_reg;
                                    fill_color_reg <= def_color_reg;
                                    ptr_reg        <= cur_addr;
                                    fill_last_reg  <= tab_last;
                                    if (tab_wrap) begin
                                        col_reg         <= '0;
                                        scroll_pend_reg <= last_row;
                                        if (!last_row) begin
                                            row_reg <= row_reg + ROW_W'(1);
                                        end
                                    end else begin
                                        col_reg <= COL_W'(tab_next);
                                    end
                                    state_reg <= S_FILL;
                                end
                                tce_pkg::CH_BACKSPACE: begin
                                    if (col_reg != '0) begin
                                        col_reg <= col_reg - COL_W'(1);
                                    end
                                end
                                tce_pkg::CH_RETURN: begin
                                    col_reg <= '0;
                                end
                                tce_pkg::CH_FORMFEED: begin
                                    fill_color_reg <= cur_color_reg;
                                    ptr_reg        <= '0;
                                    fill_last_reg  <= ADDR_W'(CELLS - 1);
                                    row_reg        <= '0;
                                    col_reg        <= '0;
                                    state_reg      <= S_FILL;
                                end
                                default: begin
                                    // cell written by the port mux this cycle
                                    if (col_inc == CX_W'(COLUMNS)) begin
                                        col_reg <= '0;
                                        if (last_row) begin
                                            state_reg <= S_SCROLL;
                                        end else begin
                                            row_reg <= row_reg + ROW_W'(1);
                                        end
                                    end else begin
                                        col_reg <= COL_W'(col_inc);
                                    end
                                end
                            endcase
                        end
                        default: begin
                            // unused mode: cursor and colors stay as they are; only a result word goes out
                        end
                    endcase
                end

                S_READ: begin
                    cell_data_reg <= mem_rd_data;
                    state_reg     <= S_DONE;
                end

                S_FILL: begin
                    if (ptr_reg == fill_last_reg) begin
                        ptr_reg   <= '0;
                        state_reg <= scroll_pend_reg ? S_SCROLL : S_DONE;
                    end else begin
                        ptr_reg <= ptr_reg + ADDR_W'(1);
                    end
                end

                S_SCROLL: begin
                    if (scroll_reads) begin
                        ptr_reg <= ptr_reg + ADDR_W'(1);
                    end else begin
                        ptr_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                end

                S_DONE: begin
                    // hold until the result register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_row_reg   <= tce_pkg::OROW_W'(row_reg);
                        m_col_reg   <= tce_pkg::OCOL_W'(col_reg);
                        m_data_reg  <= cell_data_reg;
                        state_reg   <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_row    = m_row_reg;
    assign m_cursor_column = m_col_reg;
    assign m_cell_data     = m_data_reg;

    // Cursor stays on screen
    `TCE_ASSERT_ALWAYS(a_cursor_on_screen, aclk, aresetn, (32'(row_reg) < 32'(ROWS)) && (32'(col_reg) < 32'(COLUMNS)))
    // Cell writes stay inside the store
    `TCE_ASSERT_IMPLY(a_write_in_store, aclk, aresetn, mem_wr_en, 32'(mem_wr_addr) < 32'(CELLS))
    // A new result word comes only out of the result step
    `TCE_ASSERT_IMPLY(a_result_from_done, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == S_DONE)
    // An accepted word is worked on in the next cycle
    `TCE_ASSERT_NEXT(a_accept_to_exec, aclk, aresetn, accept, state_reg == S_EXEC)

endmodule
